// ===== rtl/utp_pkg.sv =====
package utp_pkg;

   // fixed field widths
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned BASE_W   = 6;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned OFFSET_W = 12;

   // character codes
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;

   // letter digit offsets: 'A' - 10 and 'a' - 10
   localparam logic [CHAR_W-1:0] UPPER_OFS = CH_UP_A - 8'd10;
   localparam logic [CHAR_W-1:0] LOWER_OFS = CH_LO_A - 8'd10;

   // radix codes
   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

   // token queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      DS_NONE,
      DS_ANY,
      DS_OVER
   } digit_status_type;

   // classified character
   typedef struct packed {
      logic              starts_string;
      logic              is_space;
      logic              is_plus;
      logic              is_minus;
      logic              is_x;
      logic              digit_ok;
      logic [BASE_W-1:0] digit_val;
   } token_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

// ===== rtl/utp_req_if.sv =====
interface utp_req_if import utp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              starts_string;

   modport source (output valid, output char_code, output starts_string, input ready);
   modport sink (input valid, input char_code, input starts_string, output ready);
endinterface

// ===== rtl/utp_rsp_if.sv =====
interface utp_rsp_if import utp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  parsed_value;
   logic [OFFSET_W-1:0] end_offset;
   logic                overflowed;
   logic                converted_any;

   modport source (
      output valid, output parsed_value, output end_offset,
      output overflowed, output converted_any, input ready
   );
   modport sink (
      input valid, input parsed_value, input end_offset,
      input overflowed, input converted_any, output ready
   );
endinterface

// ===== rtl/utp_front.sv =====
module utp_front import utp_pkg::*; (
   utp_req_if.sink   req_chan,
   input  logic      queue_ready,
   output logic      push,
   output token_type token
);

   logic [CHAR_W-1:0] c;
   logic              is_dec;
   logic              is_upper;
   logic              is_lower;
   logic [CHAR_W-1:0] dval;

   assign c        = req_chan.char_code;
   assign is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
   assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);

   always_comb begin
      if (is_dec) begin
         dval = c - CH_ZERO;
      end else if (is_upper) begin
         dval = c - UPPER_OFS;
      end else begin
         dval = c - LOWER_OFS;
      end
   end

   assign req_chan.ready = queue_ready;
   assign push           = req_chan.valid && queue_ready;

   always_comb begin
      token.starts_string = req_chan.starts_string;
      token.is_space      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      token.is_plus       = (c == CH_PLUS);
      token.is_minus      = (c == CH_MINUS);
      token.is_x          = (c == CH_UP_X) || (c == CH_LO_X);
      token.digit_ok      = is_dec || is_upper || is_lower;
      token.digit_val     = dval[BASE_W-1:0];
   end

endmodule

// ===== rtl/utp_queue.sv =====
module utp_queue import utp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  token_type      wr_token,
   input  logic           pop,
   output token_type      rd_token,
   output queue_stat_type stat
);

   token_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_token;
      end
   end

   assign rd_token   = slot_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

// ===== rtl/utp_back.sv =====
module utp_back import utp_pkg::*; #(
   parameter int unsigned WORD_BITS  = 32,
   parameter int unsigned MAX_OFFSET = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BASE_W-1:0] cfg_base,
   input  token_type         token,
   input  queue_stat_type    queue_stat,
   output logic              pop,
   utp_rsp_if.source         rsp_chan
);

   localparam int unsigned CNT_W  = $clog2(MAX_OFFSET + 1);
   localparam int unsigned PROD_W = WORD_BITS + BASE_W;
   localparam int unsigned VEXT_W = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
   localparam int unsigned OEXT_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

   phase_type            phase_ff, phase_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 minus_ff, minus_in;
   digit_status_type     status_ff, status_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                over_ff, over_in;
   logic                any_ff, any_in;

   // state as seen by this token, after a possible restart
   phase_type            phase_w;
   logic [WORD_BITS-1:0] acc_w;
   logic                 minus_w;
   digit_status_type     status_w;
   logic [BASE_W-1:0]    base_w;
   logic [CNT_W-1:0]     count_w;

   logic                 active;
   logic                 lead_skip;
   logic                 lead_sign;
   logic                 first_char;
   logic                 zero_char;
   logic                 enter_zero;
   logic                 enter_prefix;
   logic                 take;
   digit_status_type     status_d;
   logic [BASE_W-1:0]    base_d;
   logic                 digit_hit;
   logic                 stop;
   logic                 emit;
   logic [PROD_W-1:0]    prod;
   logic                 fits;
   logic [WORD_BITS-1:0] signed_v;
   logic [VEXT_W-1:0]    value_ext;
   logic [OEXT_W-1:0]    offset_ext;

   assign pop = !queue_stat.empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (token.starts_string) begin
         phase_w  = PH_LEAD;
         acc_w    = '0;
         minus_w  = 1'b0;
         status_w = DS_NONE;
         base_w   = cfg_base;
         count_w  = '0;
      end else begin
         phase_w  = phase_ff;
         acc_w    = acc_ff;
         minus_w  = minus_ff;
         status_w = status_ff;
         base_w   = base_ff;
         count_w  = count_ff;
      end
   end

   // token classification against the current phase
   assign active       = (phase_w != PH_IDLE);
   assign zero_char    = token.digit_ok && (token.digit_val == '0);
   assign lead_skip    = (phase_w == PH_LEAD) && token.is_space;
   assign lead_sign    = (phase_w == PH_LEAD) && !token.is_space &&
                         (token.is_plus || token.is_minus);
   assign first_char   = ((phase_w == PH_LEAD) && !token.is_space &&
                          !token.is_plus && !token.is_minus) || (phase_w == PH_SIGNED);
   assign enter_zero   = first_char && zero_char &&
                         ((base_w == BASE_AUTO) || (base_w == BASE_HEX));
   assign enter_prefix = (phase_w == PH_ZERO) && token.is_x;
   assign take         = active && !lead_skip && !lead_sign && !enter_zero && !enter_prefix;

   // a leading zero that was not a prefix already counts as a digit
   assign status_d = (phase_w == PH_ZERO) ? DS_ANY : status_w;
   always_comb begin
      if (base_w == BASE_AUTO) begin
         base_d = (phase_w == PH_ZERO) ? BASE_OCT : BASE_DEC;
      end else begin
         base_d = base_w;
      end
   end

   assign digit_hit = token.digit_ok && (token.digit_val < base_d);
   assign stop      = take && !digit_hit;
   assign emit      = pop && stop;

   // one multiply-add; overflow when the top bits are not clear
   assign prod = PROD_W'(acc_w) * PROD_W'(base_d) + PROD_W'(token.digit_val);
   assign fits = (prod[PROD_W-1:WORD_BITS] == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         if (!active) begin
            phase_in = PH_IDLE;
         end else if (lead_skip) begin
            phase_in = PH_LEAD;
         end else if (lead_sign) begin
            phase_in = PH_SIGNED;
         end else if (enter_zero) begin
            phase_in = PH_ZERO;
         end else if (enter_prefix) begin
            phase_in = PH_PREFIX;
         end else if (stop) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_DIGITS;
         end
      end
   end

   // datapath and result
   always_comb begin
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      status_in = status_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      if (pop) begin
         acc_in    = acc_w;
         minus_in  = lead_sign ? token.is_minus : minus_w;
         status_in = status_w;
         base_in   = base_w;
         count_in  = count_w;
         if (active && (count_w < CNT_W'(MAX_OFFSET))) begin
            count_in = count_w + 1'b1;
         end
         if (enter_prefix) begin
            base_in = BASE_HEX;
         end
         if (take) begin
            base_in   = base_d;
            status_in = status_d;
            if (digit_hit && (status_d != DS_OVER)) begin
               if (fits) begin
                  status_in = DS_ANY;
                  acc_in    = prod[WORD_BITS-1:0];
               end else begin
                  status_in = DS_OVER;
                  acc_in    = '1;
               end
            end
         end
      end
   end

   always_comb begin
      signed_v   = (minus_w && (status_d == DS_ANY)) ? ('0 - acc_w) : acc_w;
      value_ext  = VEXT_W'(signed_v);
      offset_ext = OEXT_W'(count_w);
      value_in   = value_ff;
      offset_in  = offset_ff;
      over_in    = over_ff;
      any_in     = any_ff;
      if (emit) begin
         value_in  = value_ext[VALUE_W-1:0];
         offset_in = (status_d != DS_NONE) ? offset_ext[OFFSET_W-1:0] : '0;
         over_in   = (status_d == DS_OVER);
         any_in    = (status_d != DS_NONE);
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         status_ff    <= DS_NONE;
         base_ff      <= BASE_AUTO;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         minus_ff     <= minus_in;
         status_ff    <= status_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      offset_ff <= offset_in;
      over_ff   <= over_in;
      any_ff    <= any_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.parsed_value  = value_ff;
   assign rsp_chan.end_offset    = offset_ff;
   assign rsp_chan.overflowed    = over_ff;
   assign rsp_chan.converted_any = any_ff;

endmodule

// ===== rtl/unsigned_integer_text_parser.sv =====
// Streaming text-to-unsigned converter: one character per req beat, with
// starts_string set on the first character of each string. It skips
// leading whitespace, takes one optional sign, recognizes a 0x/0X prefix
// when the radix register is 0 or 16, picks octal after a leading zero in
// auto mode, and accumulates digits in a WORD_BITS wide register. Exactly
// one rsp beat follows the first non-digit: the value (negated on a minus
// sign unless it saturated), the stop offset, the overflow flag and
// whether any digit was taken. Characters after the stop, and characters
// before any start, produce nothing. The radix register is sampled when
// the start character reaches the converter. While rsp keeps accepting,
// the sustained rate is one character per clock; the per-character
// multiply-add of the accumulator is the critical path. A result goes
// from its stop character through the token queue and the result
// register to rsp; a stalled rsp holds the converter, fills the two-entry
// token queue and then drops req ready. No clearing pass after reset.
module unsigned_integer_text_parser import utp_pkg::*; #(
   parameter int unsigned WORD_BITS  = 32,
   parameter int unsigned MAX_OFFSET = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [BASE_W-1:0] csr_write_data,
   utp_req_if.sink           req_chan,
   utp_rsp_if.source         rsp_chan
);

   // radix register, 0 selects auto detection
   logic [BASE_W-1:0] base_cfg_ff, base_cfg_in;

   // front to queue
   logic      push;
   token_type push_token;

   // queue to back
   logic           pop;
   token_type      pop_token;
   queue_stat_type q_stat;

   assign base_cfg_in = csr_write_enable ? csr_write_data : base_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_cfg_ff <= BASE_AUTO;
      end else begin
         base_cfg_ff <= base_cfg_in;
      end
   end

   // front: classify each character into a token
   utp_front u_front (
      .req_chan    (req_chan),
      .queue_ready (!q_stat.full),
      .push        (push),
      .token       (push_token)
   );

   // short token queue so each side can stall on its own
   utp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_token (push_token),
      .pop      (pop),
      .rd_token (pop_token),
      .stat     (q_stat)
   );

   // back: phase tracking, accumulate, result register
   utp_back #(
      .WORD_BITS  (WORD_BITS),
      .MAX_OFFSET (MAX_OFFSET)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_base   (base_cfg_ff),
      .token      (pop_token),
      .queue_stat (q_stat),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // an accepted character is in the queue on the next cycle
   a_accept_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !q_stat.empty)
      else $error("accepted character missing from token queue");

   // nothing converted means an all-zero result
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.converted_any) |->
         (rsp_chan.parsed_value == '0 && rsp_chan.end_offset == '0 &&
          !rsp_chan.overflowed))
      else $error("result without digits is not zero");

   // saturation implies digits were taken
   a_over_implies_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overflowed) |-> rsp_chan.converted_any)
      else $error("overflow flagged without any digit");
`endif

endmodule
